>>> rtl/stq_pkg.sv
// shared constants, codes and types for the segment tree range query unit
package stq_pkg;

    // default geometry
    localparam int LEAVES_DEF      = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed port widths
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int BOUND_W = 11;
    localparam int MODE_W  = 3;

    // multiplier operand slice used by the product path
    localparam int MUL_CHUNK = 16;

    // combine operation codes, undefined codes behave as xor
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUM  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PROD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_XOR  = 3'd4;

    // item function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // request fields that do not depend on the value width
    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] leaf_index;
        logic [INDEX_W-1:0] range_lo;
        logic [BOUND_W-1:0] range_hi;
    } stq_req_t;

    // response status from the tree engine
    typedef struct packed {
        logic valid;
        logic index_error;
    } stq_rsp_t;

endpackage

>>> rtl/segment_tree_range_query_unit.sv
// Segment tree range query unit: mode register, input beat, tree engine, output register.
// One item is worked at a time in a sequencer over a node memory with registered reads.
// An update writes the leaf, then per tree level reads the sibling and writes the parent.
// Min, max, sum and xor combine without the multiplier; for product the multiplier takes
// a 16-bit slice of one operand per pass. A query walks up the levels and folds in at most
// two nodes per level. Index errors answer without a walk. The next beat is taken while a
// finished result waits in the output register. After reset and after every op_mode write
// a clearing pass fills all 2*LEAVES node entries with the identity of the mode; no beat is
// taken during it.
module segment_tree_range_query_unit import stq_pkg::*; #(
    parameter int LEAVES      = LEAVES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [MODE_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [INDEX_W-1:0]       s_leaf_index,
    input  logic signed [DATA_W-1:0] s_leaf_value,
    input  logic [INDEX_W-1:0]       s_range_lo,
    input  logic [BOUND_W-1:0]       s_range_hi,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_result_value,
    output logic                     m_index_error
);

    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_result_value_reg, m_result_value_next;
    logic                   m_index_error_reg, m_index_error_next;
    stq_req_t               req;
    logic [VALUE_WIDTH-1:0] req_value;
    stq_rsp_t               rsp;
    logic [VALUE_WIDTH-1:0] rsp_value;
    logic                   rsp_ready;

    // mode register
    assign mode_next = cfg_we ? cfg_wdata : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MIN;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // input beat, leaf value sign extended or cut to the node width
    assign req.func       = s_func;
    assign req.leaf_index = s_leaf_index;
    assign req.range_lo   = s_range_lo;
    assign req.range_hi   = s_range_hi;
    assign req_value      = VALUE_WIDTH'(s_leaf_value);

    stq_engine #(
        .LEAVES      (LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_stq_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_mode   (mode_reg),
        .clear     (cfg_we),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .req_value (req_value),
        .rsp       (rsp),
        .rsp_value (rsp_value),
        .rsp_ready (rsp_ready)
    );

    // output register, result sign extended from the node width
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next        = m_valid_reg;
        m_result_value_next = m_result_value_reg;
        m_index_error_next  = m_index_error_reg;
        if (rsp.valid && rsp_ready) begin
            m_valid_next        = 1'b1;
            m_result_value_next = DATA_W'(signed'(rsp_value));
            m_index_error_next  = rsp.index_error;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_value_reg <= m_result_value_next;
        m_index_error_reg  <= m_index_error_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_index_error  = m_index_error_reg;

endmodule

>>> rtl/stq_combine.sv
// combine unit: min, max, sum and xor registered at start, product over several passes
module stq_combine import stq_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [MODE_W-1:0]      op_mode,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] y
);

    localparam int CHUNK_W = (VALUE_WIDTH < MUL_CHUNK) ? VALUE_WIDTH : MUL_CHUNK;
    localparam int CHUNKS  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CNT_W   = $clog2(CHUNKS + 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_ADD  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] pp_reg, pp_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] simple;

    // operations without the multiplier
    always_comb begin
        simple = a ^ b;
        unique case (op_mode) inside
            MODE_MIN: simple = ($signed(a) < $signed(b)) ? a : b;
            MODE_MAX: simple = ($signed(a) > $signed(b)) ? a : b;
            MODE_SUM: simple = a + b;
            default:  simple = a ^ b;
        endcase
    end

    // product: one slice of b per pass, partial product registered before the add
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        pp_next    = pp_reg;
        y_next     = y_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    if (op_mode == MODE_PROD) begin
                        a_next     = a;
                        b_next     = b;
                        y_next     = '0;
                        cnt_next   = '0;
                        state_next = C_MUL;
                    end else begin
                        y_next    = simple;
                        done_next = 1'b1;
                    end
                end
            end
            C_MUL: begin
                pp_next    = VALUE_WIDTH'(a_reg * b_reg[CHUNK_W-1:0]);
                a_next     = a_reg << CHUNK_W;
                b_next     = b_reg >> CHUNK_W;
                state_next = C_ADD;
            end
            C_ADD: begin
                y_next   = y_reg + pp_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1)) begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    state_next = C_MUL;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // operand and result registers
    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        pp_reg <= pp_next;
        y_reg  <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

>>> rtl/stq_engine.sv
// tree engine: node memory, clearing pass, update and query walks
module stq_engine import stq_pkg::*; #(
    parameter int LEAVES      = LEAVES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [MODE_W-1:0]      op_mode,
    input  logic                   clear,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  stq_req_t               req,
    input  logic [VALUE_WIDTH-1:0] req_value,
    output stq_rsp_t               rsp,
    output logic [VALUE_WIDTH-1:0] rsp_value,
    input  logic                   rsp_ready
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int NA_W  = $clog2(DEPTH);
    localparam int LP_W  = NA_W + 1;
    localparam int CMP_W = ((BOUND_W > NA_W) ? BOUND_W : NA_W) + 1;

    localparam logic [3:0] E_SWEEP   = 4'd0;
    localparam logic [3:0] E_IDLE    = 4'd1;
    localparam logic [3:0] E_UP_READ = 4'd2;
    localparam logic [3:0] E_UP_WAIT = 4'd3;
    localparam logic [3:0] E_UP_COMB = 4'd4;
    localparam logic [3:0] E_Q_LOOP  = 4'd5;
    localparam logic [3:0] E_Q_RIGHT = 4'd6;
    localparam logic [3:0] E_Q_WAIT  = 4'd7;
    localparam logic [3:0] E_Q_COMB  = 4'd8;
    localparam logic [3:0] E_DONE    = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [NA_W-1:0]        sweep_ptr_reg, sweep_ptr_next;
    logic [LP_W-1:0]        l_reg, l_next;
    logic [LP_W-1:0]        r_reg, r_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   err_reg, err_next;
    logic                   right_reg, right_next;

    // heap-numbered nodes, root at 1, entry 0 unused
    logic [VALUE_WIDTH-1:0] node_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    logic                   wr_en;
    logic [NA_W-1:0]        wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [NA_W-1:0]        rd_addr;
    logic                   comb_start;
    logic                   comb_done;
    logic [VALUE_WIDTH-1:0] comb_y;
    logic                   idx_bad;
    logic                   lo_bad;
    logic                   hi_bad;

    function automatic logic [VALUE_WIDTH-1:0] identity_of(input logic [MODE_W-1:0] mode);
        logic [VALUE_WIDTH-1:0] id;
        id = '0;
        unique case (mode) inside
            MODE_MIN:           id = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            MODE_MAX:           id = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            MODE_PROD:          id = VALUE_WIDTH'(1);
            MODE_SUM, MODE_XOR: id = '0;
            default:            id = '0;
        endcase
        return id;
    endfunction

    stq_combine #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_stq_combine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_mode (op_mode),
        .start   (comb_start),
        .a       (acc_reg),
        .b       (rd_data_reg),
        .done    (comb_done),
        .y       (comb_y)
    );

    // bound checks on the request
    assign idx_bad = CMP_W'(req.leaf_index) >= CMP_W'(LEAVES);
    assign lo_bad  = CMP_W'(req.range_lo) >= CMP_W'(LEAVES);
    assign hi_bad  = CMP_W'(req.range_hi) > CMP_W'(LEAVES);

    // sequencer; an update reads only siblings of the path it writes, so one item
    // never reads an entry it has just written, and items do not overlap
    always_comb begin
        state_next     = state_reg;
        sweep_ptr_next = sweep_ptr_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        right_next     = right_reg;
        wr_en          = 1'b0;
        wr_addr        = l_reg[NA_W-1:0];
        wr_data        = comb_y;
        rd_en          = 1'b0;
        rd_addr        = l_reg[NA_W-1:0];
        comb_start     = 1'b0;
        unique case (state_reg)
            E_SWEEP: begin
                wr_en          = 1'b1;
                wr_addr        = sweep_ptr_reg;
                wr_data        = identity_of(op_mode);
                sweep_ptr_next = sweep_ptr_reg + 1'b1;
                if (sweep_ptr_reg == '1) begin
                    state_next = E_IDLE;
                end
            end
            E_IDLE: begin
                if (req_valid) begin
                    if (req.func == FUNC_UPDATE) begin
                        if (idx_bad) begin
                            acc_next   = '0;
                            err_next   = 1'b1;
                            state_next = E_DONE;
                        end else begin
                            l_next     = LP_W'(req.leaf_index) + LP_W'(LEAVES);
                            wr_en      = 1'b1;
                            wr_addr    = l_next[NA_W-1:0];
                            wr_data    = req_value;
                            acc_next   = req_value;
                            err_next   = 1'b0;
                            state_next = E_UP_READ;
                        end
                    end else begin
                        if (lo_bad || hi_bad) begin
                            acc_next   = '0;
                            err_next   = 1'b1;
                            state_next = E_DONE;
                        end else begin
                            l_next     = LP_W'(req.range_lo) + LP_W'(LEAVES);
                            r_next     = LP_W'(req.range_hi) + LP_W'(LEAVES);
                            acc_next   = identity_of(op_mode);
                            err_next   = 1'b0;
                            state_next = E_Q_LOOP;
                        end
                    end
                end
            end
            E_UP_READ: begin
                if (l_reg == LP_W'(1)) begin
                    acc_next   = '0;
                    state_next = E_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = l_reg[NA_W-1:0] ^ NA_W'(1);
                    state_next = E_UP_WAIT;
                end
            end
            E_UP_WAIT: begin
                comb_start = 1'b1;
                state_next = E_UP_COMB;
            end
            E_UP_COMB: begin
                if (comb_done) begin
                    l_next     = l_reg >> 1;
                    wr_en      = 1'b1;
                    wr_addr    = l_next[NA_W-1:0];
                    wr_data    = comb_y;
                    acc_next   = comb_y;
                    state_next = E_UP_READ;
                end
            end
            E_Q_LOOP: begin
                if (l_reg >= r_reg) begin
                    state_next = E_DONE;
                end else if (l_reg[0]) begin
                    rd_en      = 1'b1;
                    rd_addr    = l_reg[NA_W-1:0];
                    l_next     = l_reg + 1'b1;
                    right_next = 1'b0;
                    state_next = E_Q_WAIT;
                end else begin
                    state_next = E_Q_RIGHT;
                end
            end
            E_Q_RIGHT: begin
                if (r_reg[0]) begin
                    r_next     = r_reg - 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = r_next[NA_W-1:0];
                    right_next = 1'b1;
                    state_next = E_Q_WAIT;
                end else begin
                    l_next     = l_reg >> 1;
                    r_next     = r_reg >> 1;
                    state_next = E_Q_LOOP;
                end
            end
            E_Q_WAIT: begin
                comb_start = 1'b1;
                state_next = E_Q_COMB;
            end
            E_Q_COMB: begin
                if (comb_done) begin
                    acc_next = comb_y;
                    if (right_reg) begin
                        l_next     = l_reg >> 1;
                        r_next     = r_reg >> 1;
                        state_next = E_Q_LOOP;
                    end else begin
                        state_next = E_Q_RIGHT;
                    end
                end
            end
            E_DONE: begin
                if (rsp_ready) begin
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
        // a mode write restarts the clearing pass
        if (clear) begin
            state_next     = E_SWEEP;
            sweep_ptr_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_SWEEP;
            sweep_ptr_reg <= '0;
            err_reg       <= 1'b0;
            right_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_ptr_reg <= sweep_ptr_next;
            err_reg       <= err_next;
            right_reg     <= right_next;
        end
    end

    // walk pointers and accumulator
    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    assign req_ready       = (state_reg == E_IDLE) && !clear;
    assign rsp.valid       = (state_reg == E_DONE);
    assign rsp.index_error = err_reg;
    assign rsp_value       = acc_reg;

endmodule

>>> rtl/stq_checker.sv
// port level checks for the segment tree range query unit, bound to the top level
module stq_checker import stq_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     cfg_we,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_result_value,
    input logic                     m_index_error
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_index_error))
        else $error("result beat changed while stalled");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // a mode write starts the clearing pass
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input open right after a mode write");

    // an index error carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_result_value == '0)
        else $error("index error with nonzero value");

    // reset leaves both sides closed while the tree clears
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("channel open right after reset");

endmodule

bind segment_tree_range_query_unit stq_checker u_stq_checker (.*);

>>> test/tb_top.sv
// self-checking testbench for the segment tree range query unit
module tb_top;
    import stq_pkg::*;

    localparam int NUM_LEAVES = LEAVES_DEF;
    localparam int NODE_TOTAL = 2 * NUM_LEAVES - 1;
    localparam int ITEMS_PER_MODE = 210;
    localparam int DRAIN_CYCLES = 200;

    // codes above xor are kept by the block and act as xor
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI  = 3'd7;

    typedef struct {
        logic               func;
        logic [INDEX_W-1:0] leaf_index;
        logic [DATA_W-1:0]  leaf_value;
        logic [INDEX_W-1:0] range_lo;
        logic [BOUND_W-1:0] range_hi;
        int                 gap;
    } tree_req_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              index_error;
    } tree_answer_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [MODE_W-1:0]        cfg_wdata = MODE_MIN;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_func = FUNC_UPDATE;
    logic [INDEX_W-1:0]       s_leaf_index = '0;
    logic signed [DATA_W-1:0] s_leaf_value = '0;
    logic [INDEX_W-1:0]       s_range_lo = '0;
    logic [BOUND_W-1:0]       s_range_hi = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_result_value;
    logic                     m_index_error;

    segment_tree_range_query_unit #(
        .LEAVES      (NUM_LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH_DEF)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_leaf_index   (s_leaf_index),
        .s_leaf_value   (s_leaf_value),
        .s_range_lo     (s_range_lo),
        .s_range_hi     (s_range_hi),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_index_error  (m_index_error)
    );

    // shadow tree, 1-based heap numbering
    logic [DATA_W-1:0] seg_nodes [1:NODE_TOTAL];
    logic [MODE_W-1:0] cur_mode = MODE_MIN;

    tree_req_t    tree_requests[$];
    tree_answer_t expected_answers[$];
    tree_req_t    cur_req;

    int hold_cnt = 0;
    int stall_cnt = 0;
    int tx_steady = 0;
    int rx_steady = 0;
    int fail_count = 0;
    int update_count = 0;
    int query_count = 0;
    int error_count = 0;
    int mode_count = 1;

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [DATA_W-1:0] mode_identity(input logic [MODE_W-1:0] m);
        case (m)
            MODE_MIN:  return 32'h7fff_ffff;
            MODE_MAX:  return 32'h8000_0000;
            MODE_PROD: return 32'd1;
            default:   return 32'd0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] fold(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        case (cur_mode)
            MODE_MIN:  return ($signed(a) < $signed(b)) ? a : b;
            MODE_MAX:  return ($signed(a) > $signed(b)) ? a : b;
            MODE_SUM:  return a + b;
            MODE_PROD: return a * b;
            default:   return a ^ b;
        endcase
    endfunction

    function automatic void clear_tree();
        for (int n = 1; n <= NODE_TOTAL; n++) seg_nodes[n] = mode_identity(cur_mode);
    endfunction

    // apply one item to the shadow tree and return its answer
    function automatic tree_answer_t apply_tree_op(input tree_req_t r);
        tree_answer_t ans;
        int node;
        int lo_n;
        int hi_n;
        logic [DATA_W-1:0] acc;
        ans.value = '0;
        ans.index_error = 1'b0;
        if (r.func == FUNC_UPDATE) begin
            if (r.leaf_index >= NUM_LEAVES) begin
                ans.index_error = 1'b1;
                return ans;
            end
            node = r.leaf_index + NUM_LEAVES;
            seg_nodes[node] = r.leaf_value;
            while (node > 1) begin
                node = node >> 1;
                seg_nodes[node] = fold(seg_nodes[2 * node], seg_nodes[2 * node + 1]);
            end
            return ans;
        end
        if (r.range_lo >= NUM_LEAVES || r.range_hi > NUM_LEAVES) begin
            ans.index_error = 1'b1;
            return ans;
        end
        acc = mode_identity(cur_mode);
        if (r.range_lo < r.range_hi) begin
            lo_n = r.range_lo + NUM_LEAVES;
            hi_n = r.range_hi + NUM_LEAVES;
            while (lo_n < hi_n) begin
                if (lo_n[0]) begin
                    acc = fold(acc, seg_nodes[lo_n]);
                    lo_n++;
                end
                if (hi_n[0]) begin
                    hi_n--;
                    acc = fold(acc, seg_nodes[hi_n]);
                end
                lo_n = lo_n >> 1;
                hi_n = hi_n >> 1;
            end
        end
        ans.value = acc;
        return ans;
    endfunction

    // per-item sender gap, with occasional runs of back-to-back beats
    function automatic int next_gap();
        if (tx_steady > 0) begin
            tx_steady--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) tx_steady = 25;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                3:       return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        // small odd factors keep products from collapsing to zero
        if (cur_mode == MODE_PROD && roll < 80) begin
            v = 2 * $urandom_range(0, 7) + 1;
            return $urandom_range(0, 1) ? -v : v;
        end
        if (roll < 55) return $urandom_range(0, 200) - 100;
        return $urandom();
    endfunction

    task automatic push_update(input int idx, input logic [DATA_W-1:0] val);
        tree_req_t r;
        r.func = FUNC_UPDATE;
        r.leaf_index = INDEX_W'(idx);
        r.leaf_value = val;
        r.range_lo = INDEX_W'($urandom());
        r.range_hi = BOUND_W'($urandom());
        r.gap = next_gap();
        tree_requests.push_back(r);
    endtask

    task automatic push_query(input int lo, input int hi);
        tree_req_t r;
        r.func = FUNC_QUERY;
        r.leaf_index = INDEX_W'($urandom());
        r.leaf_value = $urandom();
        r.range_lo = INDEX_W'(lo);
        r.range_hi = BOUND_W'(hi);
        r.gap = next_gap();
        tree_requests.push_back(r);
    endtask

    // random traffic focused on a moving window of leaves
    task automatic queue_random(input int count);
        int win_lo;
        int win_len;
        int roll;
        int lo;
        win_lo = 0;
        win_len = 4;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                win_len = $urandom_range(4, 64);
                win_lo = $urandom_range(0, NUM_LEAVES - 65);
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                push_update(win_lo + $urandom_range(0, win_len - 1), pick_value());
            end else if (roll < 55) begin
                push_update($urandom_range(0, NUM_LEAVES - 1), pick_value());
            end else if (roll < 85) begin
                push_query(win_lo + $urandom_range(0, win_len),
                           win_lo + $urandom_range(0, win_len));
            end else if (roll < 93) begin
                push_query($urandom_range(0, NUM_LEAVES - 1), $urandom_range(0, NUM_LEAVES));
            end else if (roll < 97) begin
                push_query($urandom_range(0, NUM_LEAVES - 1),
                           $urandom_range(NUM_LEAVES + 1, 2047));
            end else begin
                lo = $urandom_range(0, NUM_LEAVES - 1);
                case ($urandom_range(0, 2))
                    0:       push_query(lo, lo);
                    1:       push_query(lo, NUM_LEAVES);
                    default: push_query(0, NUM_LEAVES);
                endcase
            end
        end
    endtask

    // wait until no beat is queued, in flight or owed
    task automatic wait_idle();
        do @(posedge aclk);
        while (tree_requests.size() != 0 || s_valid || expected_answers.size() != 0);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_mode = m;
        clear_tree();
        mode_count++;
    endtask

    task automatic present_beat(input tree_req_t r);
        cur_req <= r;
        s_valid <= 1'b1;
        s_func <= r.func;
        s_leaf_index <= r.leaf_index;
        s_leaf_value <= r.leaf_value;
        s_range_lo <= r.range_lo;
        s_range_hi <= r.range_hi;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            hold_cnt <= 0;
        end else if (s_valid && s_ready) begin
            tree_answer_t ans;
            ans = apply_tree_op(cur_req);
            expected_answers.push_back(ans);
            if (cur_req.func == FUNC_UPDATE) update_count++;
            else query_count++;
            if (ans.index_error) error_count++;
            if (tree_requests.size() != 0 && tree_requests[0].gap == 0) begin
                present_beat(tree_requests.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
            hold_cnt <= 0;
        end else if (!s_valid && tree_requests.size() != 0) begin
            if (hold_cnt + 1 >= tree_requests[0].gap) begin
                present_beat(tree_requests.pop_front());
                hold_cnt <= 0;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin : result_monitor
        int stall;
        tree_answer_t exp_ans;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cnt <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual value %h error %b",
                         $time, m_result_value, m_index_error);
                fail_count++;
            end else begin
                exp_ans = expected_answers.pop_front();
                if (m_result_value !== exp_ans.value) begin
                    $display("%0t: result_value mismatch, expected %h actual %h",
                             $time, exp_ans.value, m_result_value);
                    fail_count++;
                end
                if (m_index_error !== exp_ans.index_error) begin
                    $display("%0t: index_error mismatch, expected %b actual %b",
                             $time, exp_ans.index_error, m_index_error);
                    fail_count++;
                end
            end
            // receiver stall before the next result
            stall = (rx_steady > 0) ? 0 : $urandom_range(0, 6);
            rx_steady <= (rx_steady > 0) ? rx_steady - 1 :
                         (($urandom_range(0, 29) == 0) ? 25 : 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                stall_cnt <= stall;
            end
        end else if (!m_ready) begin
            if (stall_cnt > 1) stall_cnt <= stall_cnt - 1;
            else m_ready <= 1'b1;
        end
    end

    // stimulus and end of run
    initial begin
        logic [MODE_W-1:0] mode_seq [8];
        mode_seq = '{MODE_MAX, MODE_SUM, MODE_PROD, MODE_XOR,
                     MODE_UNDEF_LO, MODE_UNDEF_MID, MODE_UNDEF_HI, MODE_MIN};
        clear_tree();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: tree cleared to min identity by reset
        push_query(0, NUM_LEAVES);
        push_update(0, 32'h8000_0000);
        push_update(NUM_LEAVES - 1, 32'h7fff_ffff);
        push_update(NUM_LEAVES / 2, 32'hffff_ffff);
        push_update(NUM_LEAVES / 2 - 1, 32'h0000_0000);
        push_query(0, NUM_LEAVES);
        push_query(0, 1);
        push_query(NUM_LEAVES - 1, NUM_LEAVES);
        push_query(NUM_LEAVES / 2 - 1, NUM_LEAVES / 2 + 1);
        // empty and reversed ranges
        push_query(5, 5);
        push_query(NUM_LEAVES - 1, 0);
        // bounds past the last leaf
        push_query(0, NUM_LEAVES + 1);
        push_query(NUM_LEAVES - 1, 2047);
        push_update(NUM_LEAVES - 1, 32'h8000_0000);
        push_query(NUM_LEAVES / 2, NUM_LEAVES);
        push_update(1, 32'd12345);
        push_query(1, 2);
        queue_random(ITEMS_PER_MODE);

        // one phase per mode setting, each starting from a cleared tree
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_mode(mode_seq[p]);
            queue_random(ITEMS_PER_MODE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d leaf updates and %0d range queries over %0d mode settings",
                 update_count, query_count, mode_count);
        $display("%0d items answered with an index error, %0d failures",
                 error_count, fail_count);
        if (fail_count == 0 && expected_answers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
